### sv/plti_pkg.sv
// ----------------------------------------------------------------------------
// plti_pkg
// Shared types, constants and the control store of the table interpolator.
// ----------------------------------------------------------------------------
package plti_pkg;

   localparam int MAX_POINTS_DEF = 16;
   localparam int TIME_W = 32;
   localparam int LOAD_W = 32;
   localparam int INDEX_W = 4;
   localparam int STATUS_W = 3;
   localparam int CSR_W = 5;
   localparam int FRAC_W = 16;

   localparam logic [CSR_W-1:0] PTS_RESET = 5'd2;

   localparam logic OPER_STORE = 1'b0;
   localparam logic OPER_QUERY = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_EXACT = 3'd0,
      ST_INTERP = 3'd1,
      ST_RANGE = 3'd2,
      ST_STORED = 3'd3,
      ST_REJECT = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_RD_PRED,
      OP_WRITE,
      OP_RES_REJECT,
      OP_SCAN_INIT,
      OP_SCAN,
      OP_RES_EXACT,
      OP_RES_RANGE,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_MUL,
      OP_RES_INTERP,
      OP_EMIT
   } dp_op_type;

   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_BEAT,
      C_QUERY,
      C_IDX_BAD,
      C_IDX_ZERO,
      C_PRED_BAD,
      C_SCAN_BUSY,
      C_EXACT,
      C_SEG,
      C_DIV_BUSY,
      C_OUT_FREE
   } cond_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_ST_CHECK,
      S_ST_PRED,
      S_ST_ORDER,
      S_ST_WRITE,
      S_ST_REJECT,
      S_Q_INIT,
      S_Q_SCAN,
      S_Q_EXACT_CHK,
      S_Q_SEG_CHK,
      S_Q_RANGE,
      S_Q_EXACT,
      S_Q_DIV_INIT,
      S_Q_DIV,
      S_Q_MUL,
      S_Q_ADD,
      S_EMIT,
      S_EMIT_WAIT
   } step_type;

   typedef struct packed {
      dp_op_type op;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   typedef struct packed {
      logic req_valid;
      logic is_query;
      logic idx_bad;
      logic idx_zero;
      logic pred_bad;
      logic scan_busy;
      logic exact;
      logic seg;
      logic div_busy;
      logic out_free;
   } cond_flags_type;

   function automatic ctrl_word_type cw(input dp_op_type op, input cond_type cond,
                                        input step_type target);
      ctrl_word_type w;
      w.op = op;
      w.cond = cond;
      w.target = target;
      return w;
   endfunction

   // control store: jump to target when cond holds, else next step
   function automatic ctrl_word_type ucode(input step_type step);
      ctrl_word_type w;
      unique case (step)
         S_IDLE:        w = cw(OP_ACCEPT, C_NO_BEAT, S_IDLE);
         S_DISPATCH:    w = cw(OP_NONE, C_QUERY, S_Q_INIT);
         S_ST_CHECK:    w = cw(OP_NONE, C_IDX_BAD, S_ST_REJECT);
         S_ST_PRED:     w = cw(OP_RD_PRED, C_IDX_ZERO, S_ST_WRITE);
         S_ST_ORDER:    w = cw(OP_NONE, C_PRED_BAD, S_ST_REJECT);
         S_ST_WRITE:    w = cw(OP_WRITE, C_ALWAYS, S_EMIT);
         S_ST_REJECT:   w = cw(OP_RES_REJECT, C_ALWAYS, S_EMIT);
         S_Q_INIT:      w = cw(OP_SCAN_INIT, C_NEVER, S_IDLE);
         S_Q_SCAN:      w = cw(OP_SCAN, C_SCAN_BUSY, S_Q_SCAN);
         S_Q_EXACT_CHK: w = cw(OP_NONE, C_EXACT, S_Q_EXACT);
         S_Q_SEG_CHK:   w = cw(OP_NONE, C_SEG, S_Q_DIV_INIT);
         S_Q_RANGE:     w = cw(OP_RES_RANGE, C_ALWAYS, S_EMIT);
         S_Q_EXACT:     w = cw(OP_RES_EXACT, C_ALWAYS, S_EMIT);
         S_Q_DIV_INIT:  w = cw(OP_DIV_INIT, C_NEVER, S_IDLE);
         S_Q_DIV:       w = cw(OP_DIV_STEP, C_DIV_BUSY, S_Q_DIV);
         S_Q_MUL:       w = cw(OP_MUL, C_NEVER, S_IDLE);
         S_Q_ADD:       w = cw(OP_RES_INTERP, C_ALWAYS, S_EMIT);
         S_EMIT:        w = cw(OP_EMIT, C_OUT_FREE, S_IDLE);
         S_EMIT_WAIT:   w = cw(OP_NONE, C_ALWAYS, S_EMIT);
         default:       w = cw(OP_NONE, C_ALWAYS, S_IDLE);
      endcase
      return w;
   endfunction

endpackage

### sv/plti_req_if.sv
// ----------------------------------------------------------------------------
// plti_req_if
// Request channel: store or query beats toward the interpolator.
// ----------------------------------------------------------------------------
interface plti_req_if;
   logic valid;
   logic ready;
   logic operation;
   logic [plti_pkg::INDEX_W-1:0] point_index;
   logic [plti_pkg::TIME_W-1:0] point_time;
   logic signed [plti_pkg::LOAD_W-1:0] point_load;
   logic [plti_pkg::TIME_W-1:0] query_time;

   modport source (
      output valid, operation, point_index, point_time, point_load, query_time,
      input ready
   );
   modport sink (
      input valid, operation, point_index, point_time, point_load, query_time,
      output ready
   );
endinterface

### sv/plti_rsp_if.sv
// ----------------------------------------------------------------------------
// plti_rsp_if
// Response channel: one result beat per request beat.
// ----------------------------------------------------------------------------
interface plti_rsp_if;
   logic valid;
   logic ready;
   logic signed [plti_pkg::LOAD_W-1:0] load_value;
   logic [plti_pkg::STATUS_W-1:0] status;

   modport source (
      output valid, load_value, status,
      input ready
   );
   modport sink (
      input valid, load_value, status,
      output ready
   );
endinterface

### sv/plti_ram.sv
// ----------------------------------------------------------------------------
// plti_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module plti_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### sv/plti_seq.sv
// ----------------------------------------------------------------------------
// plti_seq
// Microcode sequencer: step counter, control store and condition select.
// ----------------------------------------------------------------------------
module plti_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  plti_pkg::cond_flags_type flags,
   output plti_pkg::ctrl_word_type  ctrl
);

   plti_pkg::step_type upc_ff;
   plti_pkg::step_type upc_in;
   logic cond_hit;

   assign ctrl = plti_pkg::ucode(upc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= plti_pkg::S_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

   always_comb begin
      unique case (ctrl.cond)
         plti_pkg::C_NEVER:     cond_hit = 1'b0;
         plti_pkg::C_ALWAYS:    cond_hit = 1'b1;
         plti_pkg::C_NO_BEAT:   cond_hit = !flags.req_valid;
         plti_pkg::C_QUERY:     cond_hit = flags.is_query;
         plti_pkg::C_IDX_BAD:   cond_hit = flags.idx_bad;
         plti_pkg::C_IDX_ZERO:  cond_hit = flags.idx_zero;
         plti_pkg::C_PRED_BAD:  cond_hit = flags.pred_bad;
         plti_pkg::C_SCAN_BUSY: cond_hit = flags.scan_busy;
         plti_pkg::C_EXACT:     cond_hit = flags.exact;
         plti_pkg::C_SEG:       cond_hit = flags.seg;
         plti_pkg::C_DIV_BUSY:  cond_hit = flags.div_busy;
         plti_pkg::C_OUT_FREE:  cond_hit = flags.out_free;
         default:               cond_hit = 1'b1;
      endcase
      if (cond_hit) begin
         upc_in = ctrl.target;
      end else begin
         upc_in = plti_pkg::step_type'(5'(upc_ff + 5'd1));
      end
   end

endmodule

### sv/plti_dp.sv
// ----------------------------------------------------------------------------
// plti_dp
// Datapath: breakpoint table, scan compare, restoring divider, multiply and
// output register, all driven by the sequencer's control word.
// ----------------------------------------------------------------------------
module plti_dp #(
   parameter int MAX_POINTS = plti_pkg::MAX_POINTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  plti_pkg::ctrl_word_type       ctrl,
   output plti_pkg::cond_flags_type      flags,
   plti_req_if.sink                      req,
   plti_rsp_if.source                    rsp,
   input  logic                          csr_wr_en,
   input  logic [plti_pkg::CSR_W-1:0]    csr_wr_data
);

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int TW = plti_pkg::TIME_W;
   localparam int LW = plti_pkg::LOAD_W;
   localparam int FW = plti_pkg::FRAC_W;
   localparam int DC_W = $clog2(FW);
   localparam int PROD_W = FW + LW + 2;

   // latched request
   logic                            oper_ff, oper_in;
   logic [plti_pkg::INDEX_W-1:0]    idx_ff, idx_in;
   logic [TW-1:0]                   ptime_ff, ptime_in;
   logic signed [LW-1:0]            pload_ff, pload_in;
   logic [TW-1:0]                   q_ff, q_in;
   logic [plti_pkg::CSR_W-1:0]      pts_ff, pts_in;

   // scan
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic [CNT_W-1:0]                n_cnt;
   logic                            rd_pend_ff, rd_pend_in;
   logic                            have_prev_ff, have_prev_in;
   logic [TW-1:0]                   prev_t_ff, prev_t_in;
   logic signed [LW-1:0]            prev_l_ff, prev_l_in;
   logic                            exact_ff, exact_in;
   logic                            seg_ff, seg_in;
   logic                            scan_more;

   // divide / multiply
   logic [TW-1:0]                   rem_ff, rem_in;
   logic [TW-1:0]                   den_ff, den_in;
   logic [FW-1:0]                   quot_ff, quot_in;
   logic [DC_W-1:0]                 divc_ff, divc_in;
   logic signed [LW:0]              dl_ff, dl_in;
   logic signed [LW-1:0]            l0_ff, l0_in;
   logic signed [PROD_W-1:0]        prod_ff, prod_in;
   logic [TW:0]                     rem_sh;
   logic [TW:0]                     rem_diff;
   logic                            rem_ge;
   logic signed [PROD_W-1:0]        interp_sum;

   // result
   logic signed [LW-1:0]            res_load_ff, res_load_in;
   plti_pkg::status_type            res_status_ff, res_status_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic signed [LW-1:0]            rsp_load_ff, rsp_load_in;
   plti_pkg::status_type            rsp_status_ff, rsp_status_in;
   logic                            out_free;

   // table
   logic                            ram_wr_en;
   logic [IDX_W-1:0]                ram_wr_addr;
   logic                            ram_rd_en;
   logic [IDX_W-1:0]                ram_rd_addr;
   logic [TW+LW-1:0]                ram_rd_data;
   logic [TW-1:0]                   rd_time;
   logic signed [LW-1:0]            rd_load;

   plti_ram #(
      .WIDTH (TW + LW),
      .DEPTH (MAX_POINTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data ({ptime_ff, pload_ff}),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_time = ram_rd_data[TW+LW-1:LW];
   assign rd_load = ram_rd_data[LW-1:0];

   always_comb begin
      if (32'(pts_ff) > 32'(MAX_POINTS)) begin
         n_cnt = CNT_W'(MAX_POINTS);
      end else begin
         n_cnt = CNT_W'(pts_ff);
      end
   end

   assign scan_more = cnt_ff < n_cnt;
   assign out_free = !rsp_valid_ff || rsp.ready;

   assign ram_wr_en = ctrl.op == plti_pkg::OP_WRITE;
   assign ram_wr_addr = IDX_W'(idx_ff);
   assign ram_rd_en = (ctrl.op == plti_pkg::OP_RD_PRED) ||
                      ((ctrl.op == plti_pkg::OP_SCAN) && scan_more);
   assign ram_rd_addr = (ctrl.op == plti_pkg::OP_RD_PRED) ?
                        IDX_W'(32'(idx_ff) - 32'd1) : cnt_ff[IDX_W-1:0];

   assign flags.req_valid = req.valid;
   assign flags.is_query = oper_ff == plti_pkg::OPER_QUERY;
   assign flags.idx_bad = 32'(idx_ff) >= 32'(MAX_POINTS);
   assign flags.idx_zero = idx_ff == '0;
   assign flags.pred_bad = ptime_ff < rd_time;
   assign flags.scan_busy = scan_more || rd_pend_ff;
   assign flags.exact = exact_ff;
   assign flags.seg = seg_ff;
   assign flags.div_busy = divc_ff != '0;
   assign flags.out_free = out_free;

   assign req.ready = ctrl.op == plti_pkg::OP_ACCEPT;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.load_value = rsp_load_ff;
   assign rsp.status = rsp_status_ff;

   assign rem_sh = {rem_ff, 1'b0};
   assign rem_ge = rem_sh >= {1'b0, den_ff};
   assign rem_diff = rem_sh - {1'b0, den_ff};
   assign interp_sum = PROD_W'(l0_ff) + (prod_ff >>> FW);

   always_comb begin
      oper_in = oper_ff;
      idx_in = idx_ff;
      ptime_in = ptime_ff;
      pload_in = pload_ff;
      q_in = q_ff;
      pts_in = csr_wr_en ? csr_wr_data : pts_ff;
      cnt_in = cnt_ff;
      rd_pend_in = rd_pend_ff;
      have_prev_in = have_prev_ff;
      prev_t_in = prev_t_ff;
      prev_l_in = prev_l_ff;
      exact_in = exact_ff;
      seg_in = seg_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      quot_in = quot_ff;
      divc_in = divc_ff;
      dl_in = dl_ff;
      l0_in = l0_ff;
      prod_in = prod_ff;
      res_load_in = res_load_ff;
      res_status_in = res_status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_load_in = rsp_load_ff;
      rsp_status_in = rsp_status_ff;

      unique case (ctrl.op)
         plti_pkg::OP_ACCEPT: begin
            if (req.valid) begin
               oper_in = req.operation;
               idx_in = req.point_index;
               ptime_in = req.point_time;
               pload_in = req.point_load;
               q_in = req.query_time;
            end
         end
         plti_pkg::OP_WRITE: begin
            res_load_in = '0;
            res_status_in = plti_pkg::ST_STORED;
         end
         plti_pkg::OP_RES_REJECT: begin
            res_load_in = '0;
            res_status_in = plti_pkg::ST_REJECT;
         end
         plti_pkg::OP_SCAN_INIT: begin
            cnt_in = '0;
            rd_pend_in = 1'b0;
            have_prev_in = 1'b0;
            exact_in = 1'b0;
            seg_in = 1'b0;
         end
         plti_pkg::OP_SCAN: begin
            // compare the entry read last cycle, issue the next read
            if (rd_pend_ff) begin
               if (!exact_ff && (rd_time == q_ff)) begin
                  exact_in = 1'b1;
                  res_load_in = rd_load;
               end
               if (!seg_ff && have_prev_ff && (prev_t_ff < q_ff) && (q_ff < rd_time)) begin
                  seg_in = 1'b1;
                  rem_in = q_ff - prev_t_ff;
                  den_in = rd_time - prev_t_ff;
                  dl_in = (LW + 1)'(rd_load) - (LW + 1)'(prev_l_ff);
                  l0_in = prev_l_ff;
               end
               prev_t_in = rd_time;
               prev_l_in = rd_load;
               have_prev_in = 1'b1;
            end
            if (scan_more) begin
               cnt_in = CNT_W'(cnt_ff + 1'b1);
            end
            rd_pend_in = scan_more;
         end
         plti_pkg::OP_RES_EXACT: begin
            res_status_in = plti_pkg::ST_EXACT;
         end
         plti_pkg::OP_RES_RANGE: begin
            res_load_in = '0;
            res_status_in = plti_pkg::ST_RANGE;
         end
         plti_pkg::OP_DIV_INIT: begin
            quot_in = '0;
            divc_in = DC_W'(FW - 1);
         end
         plti_pkg::OP_DIV_STEP: begin
            // remainder stays below the divisor, quotient below 1.0
            rem_in = rem_ge ? rem_diff[TW-1:0] : rem_sh[TW-1:0];
            quot_in = {quot_ff[FW-2:0], rem_ge};
            divc_in = DC_W'(divc_ff - 1'b1);
         end
         plti_pkg::OP_MUL: begin
            prod_in = $signed({1'b0, quot_ff}) * dl_ff;
         end
         plti_pkg::OP_RES_INTERP: begin
            res_load_in = interp_sum[LW-1:0];
            res_status_in = plti_pkg::ST_INTERP;
         end
         plti_pkg::OP_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_load_in = res_load_ff;
               rsp_status_in = res_status_ff;
            end
         end
         plti_pkg::OP_NONE,
         plti_pkg::OP_RD_PRED: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pts_ff <= plti_pkg::PTS_RESET;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
         exact_ff <= 1'b0;
         seg_ff <= 1'b0;
         divc_ff <= '0;
      end else begin
         pts_ff <= pts_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff <= rd_pend_in;
         exact_ff <= exact_in;
         seg_ff <= seg_in;
         divc_ff <= divc_in;
      end
   end

   always_ff @(posedge clock) begin
      oper_ff <= oper_in;
      idx_ff <= idx_in;
      ptime_ff <= ptime_in;
      pload_ff <= pload_in;
      q_ff <= q_in;
      cnt_ff <= cnt_in;
      have_prev_ff <= have_prev_in;
      prev_t_ff <= prev_t_in;
      prev_l_ff <= prev_l_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quot_ff <= quot_in;
      dl_ff <= dl_in;
      l0_ff <= l0_in;
      prod_ff <= prod_in;
      res_load_ff <= res_load_in;
      res_status_ff <= res_status_in;
      rsp_load_ff <= rsp_load_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

### sv/piecewise_linear_table_interp.sv
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp
// Breakpoint table with exact-match lookup and linear interpolation.
//
// req_bus carries one beat per item: a store writes entry point_index with
// (point_time, point_load); a query asks for the load at query_time. Every
// request beat yields exactly one rsp_bus beat with load_value and status.
// csr_wr_en/csr_wr_data set the number of entries a query searches
// (reset value 2); write it only while no item is in flight.
// One item is processed at a time; the next request beat is taken once the
// previous result has moved into the output register. A store rejects an
// out-of-range index, else reads the preceding entry (skipped for entry 0),
// rejects a point_time below it and otherwise writes the entry. A query
// scans one entry per cycle through the table's single read port, then
// returns an exact match, or runs a 16-step restoring divide and one
// multiply to interpolate, or reports out of range.
// Reset puts the sequencer in idle, drops rsp valid and sets the entry count
// to 2; the table is not cleared. A stalled receiver holds the result in the
// output register; the next request beat is still taken and processed up to
// its own result, which then waits for the register to drain.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interp #(
   parameter int MAX_POINTS = plti_pkg::MAX_POINTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   plti_req_if.sink                      req_bus,
   plti_rsp_if.source                    rsp_bus,
   input  logic                          csr_wr_en,
   input  logic [plti_pkg::CSR_W-1:0]    csr_wr_data
);

   plti_pkg::ctrl_word_type  ctrl;
   plti_pkg::cond_flags_type flags;

   plti_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   plti_dp #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .flags       (flags),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   a_beat_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request accepted without leaving idle");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(ctrl.op == plti_pkg::OP_EMIT))
      else $error("response valid raised outside emit step");

   a_div_needs_segment: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == plti_pkg::OP_DIV_INIT) |-> (flags.seg && !flags.exact))
      else $error("divide started without a bracketing segment");

endmodule
